>>> src/radc_pkg.sv
package radc_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int RESULT_CAP = 31;
  localparam int VALUE_W    = 31;
  localparam int RADIX_W    = 7;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;
  localparam int RECIP_W    = 32;
  localparam int PROD_W     = VALUE_W + RECIP_W;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_RADIX   = '0;
  localparam logic [RADIX_W-1:0]   RADIX_RESET = 7'd10;
  localparam logic [RADIX_W-1:0]   RADIX_MIN   = 7'd2;
  localparam logic [RADIX_W-1:0]   RADIX_SMALL = 7'd16;
  localparam logic [RADIX_W-1:0]   RADIX_B64   = 7'd64;

  localparam logic [RECIP_W:0] RECIP_ONE = {1'b1, {RECIP_W{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_EMIT,
    ST_ERR
  } radc_state_t;

  function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
    return ((r >= RADIX_MIN) && (r <= RADIX_SMALL)) || (r == RADIX_B64);
  endfunction

  // floor(2^32 / r): quotient estimate is exact or one short
  function automatic logic [RECIP_W-1:0] radix_recip(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    m = '0;
    case (r)
      7'd2:    m = RECIP_W'(RECIP_ONE / 2);
      7'd3:    m = RECIP_W'(RECIP_ONE / 3);
      7'd4:    m = RECIP_W'(RECIP_ONE / 4);
      7'd5:    m = RECIP_W'(RECIP_ONE / 5);
      7'd6:    m = RECIP_W'(RECIP_ONE / 6);
      7'd7:    m = RECIP_W'(RECIP_ONE / 7);
      7'd8:    m = RECIP_W'(RECIP_ONE / 8);
      7'd9:    m = RECIP_W'(RECIP_ONE / 9);
      7'd10:   m = RECIP_W'(RECIP_ONE / 10);
      7'd11:   m = RECIP_W'(RECIP_ONE / 11);
      7'd12:   m = RECIP_W'(RECIP_ONE / 12);
      7'd13:   m = RECIP_W'(RECIP_ONE / 13);
      7'd14:   m = RECIP_W'(RECIP_ONE / 14);
      7'd15:   m = RECIP_W'(RECIP_ONE / 15);
      7'd16:   m = RECIP_W'(RECIP_ONE / 16);
      7'd64:   m = RECIP_W'(RECIP_ONE / 64);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = 7'h30 + CHAR_W'(d);
    end else if (d < 6'd36) begin
      c = 7'h41 + CHAR_W'(d - 6'd10);
    end else if (d < 6'd62) begin
      c = 7'h61 + CHAR_W'(d - 6'd36);
    end else if (d == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

>>> src/radix_digit_converter.sv
// radix_digit_converter: turns one unsigned 31-bit value into its digits in
// the base held in the radix register (2..16 or 64), sent as ASCII words
// most significant first, with out_last on the final word.
// input channel: in_value with in_valid/in_ready; output channel:
// out_digit_char, out_last, out_error with out_valid/out_ready.
// config: APB-style, radix at byte address 0; the user must write it only
// while idle, as the block itself does not enforce this. one shared
// multiply-by-reciprocal unit splits off each digit by a multiply, then a
// remainder fix-up, least significant first, into a small digit store;
// the digits are then read back in reverse, one word a cycle while the
// receiver takes them; the value zero gives one '0'.
// an unsupported radix gives a single word with out_error set, out_last
// set and character code 0, loaded once the output register is free.
// in_ready is high only while the sequencer is idle; the output register
// lets a new value be taken while the previous final word still waits.
// a stalled receiver simply holds the read-back where it is.
// reset (rst_n low, synchronous) empties the output and sets radix to 10.
module radix_digit_converter
  import radc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAR_W-1:0]    out_digit_char,
  output logic                 out_last,
  output logic                 out_error,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_W-1:0]    cfg_paddr,
  input  logic [DATA_W-1:0]    cfg_pwdata,
  output logic [DATA_W-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  radc_state_t          state_r, state_nxt;
  logic [RADIX_W-1:0]   radix_r;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     emit_idx_r, emit_idx_nxt;
  logic [DIGIT_W-1:0]   store_r [MAX_DIGITS];

  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_error_r, out_error_nxt;

  logic                 in_fire;
  logic                 out_load;
  logic                 cfg_wr;
  logic [PROD_W-1:0]    prod;
  logic [RADIX_W-1:0]   qr_lo;
  logic [RADIX_W-1:0]   rem_raw;
  logic                 need_fix;
  logic [RADIX_W-1:0]   rem_fix;
  logic [VALUE_W-1:0]   quo_fix;
  logic                 store_wr;
  logic [CNT_W-1:0]     emit_n;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[ADDR_W-1:2] == REG_RADIX)
                      ? DATA_W'(radix_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr && (cfg_paddr[ADDR_W-1:2] == REG_RADIX)) begin
      radix_r <= cfg_pwdata[RADIX_W-1:0];
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = ((state_r == ST_EMIT) || (state_r == ST_ERR))
                    && (!out_valid_r || out_ready);

  // shared divide unit: quotient estimate, then low-bit remainder fix-up
  assign prod     = PROD_W'(val_r) * PROD_W'(radix_recip(radix_r));
  assign qr_lo    = quo_r[RADIX_W-1:0] * radix_r;
  assign rem_raw  = val_r[RADIX_W-1:0] - qr_lo;
  assign need_fix = (rem_raw >= radix_r);
  assign rem_fix  = need_fix ? (rem_raw - radix_r) : rem_raw;
  assign quo_fix  = quo_r + VALUE_W'(need_fix);
  assign store_wr = (state_r == ST_FIX) && (cnt_r < CNT_W'(MAX_DIGITS));
  assign emit_n   = (cnt_r >= CNT_W'(RESULT_CAP)) ? CNT_W'(RESULT_CAP)
                    : (cnt_r + CNT_W'(store_wr));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = radix_ok(radix_r) ? ST_MUL : ST_ERR;
        end
      end
      ST_MUL: begin
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        state_nxt = (quo_fix == '0) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (out_load && (emit_idx_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    val_nxt       = val_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    emit_idx_nxt  = emit_idx_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_error_nxt = out_error_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          val_nxt = radix_ok(radix_r) ? in_value : '0;
          cnt_nxt = '0;
        end
      end
      ST_MUL: begin
        quo_nxt = prod[PROD_W-1:RECIP_W];
      end
      ST_FIX: begin
        val_nxt = quo_fix;
        if (store_wr) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        emit_idx_nxt = IDX_W'(emit_n - CNT_W'(1));
      end
      ST_EMIT: begin
        if (out_load) begin
          out_char_nxt  = digit_ascii(store_r[emit_idx_r]);
          out_last_nxt  = (emit_idx_r == '0);
          out_error_nxt = 1'b0;
          if (emit_idx_r != '0) begin
            emit_idx_nxt = emit_idx_r - IDX_W'(1);
          end
        end
      end
      ST_ERR: begin
        if (out_load) begin
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_error_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      val_r       <= '0;
      cnt_r       <= '0;
      emit_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      val_r       <= val_nxt;
      cnt_r       <= cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r       <= quo_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
    if (store_wr) begin
      store_r[cnt_r[IDX_W-1:0]] <= rem_fix[DIGIT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_error      = out_error_r;

  // the reciprocal estimate is never more than one short
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> ({1'b0, rem_raw} < {radix_r, 1'b0}))
    else $error("quotient estimate off by more than one");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_last_r && (out_char_r == '0)))
    else $error("error word not a lone zero final word");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_FIX))
    else $error("multiply step not followed by fix-up");

endmodule

>>> dv/radix_digit_converter_test.sv
`timescale 1ns / 1ps

module radix_digit_converter_test;
  import radc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 100;
  localparam int STALL_LIMIT   = 3000;
  localparam int NUM_VECTORS   = 25;
  localparam int TEXT_W        = 31 * 8;

  localparam logic [ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_RADIX, 2'b00};

  // digits as typed text, most significant first; zero means use the predictor
  localparam logic [TEXT_W-1:0] PREDICT  = '0;
  localparam logic [TEXT_W-1:0] BAD_BASE = "!";

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
    logic              error;
  } ascii_word_t;

  typedef struct packed {
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  wdata;
    logic [VALUE_W-1:0] value;
    logic [TEXT_W-1:0]  text;
  } vector_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last;
  logic               out_error;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]  cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  string glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";

  ascii_word_t        pending_digits[$];
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  bit                 steady = 1'b0;
  int                 fault_count = 0;
  int                 values_sent = 0;
  int                 words_seen = 0;
  int                 radix_writes = 0;
  int                 stall_cycles = 0;
  vector_t            vectors [NUM_VECTORS];

  radix_digit_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_error      (out_error),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < 19);
  endfunction

  // digits of v in the current base, least significant kept first, sent reversed
  function automatic void predict_digits(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] store [MAX_DIGITS];
    int unsigned base, rest, held, shown, shift;
    byte ch;
    ascii_word_t w;
    base = radix_reg;
    held = 0;
    rest = v;
    if (!((base >= 2 && base <= 16) || base == 64)) begin
      w.glyph = '0;
      w.last  = 1'b1;
      w.error = 1'b1;
      pending_digits.push_back(w);
      return;
    end
    if (rest == 0) begin
      store[0] = '0;
      held = 1;
    end else if ((base & (base - 1)) == 0) begin
      shift = $clog2(base);
      while (rest > 0) begin
        if (held < MAX_DIGITS) begin
          store[held] = DIGIT_W'(rest & (base - 1));
          held++;
        end
        rest = rest >> shift;
      end
    end else begin
      while (rest > 0) begin
        if (held < MAX_DIGITS) begin
          store[held] = DIGIT_W'(rest % base);
          held++;
        end
        rest = rest / base;
      end
    end
    shown = (held > RESULT_CAP) ? RESULT_CAP : held;
    for (int k = 0; k < shown; k++) begin
      ch = glyphs[store[shown - 1 - k]];
      w.glyph = ch[CHAR_W-1:0];
      w.last  = (k + 1 == shown);
      w.error = 1'b0;
      pending_digits.push_back(w);
    end
  endfunction

  function automatic void expect_text(input logic [TEXT_W-1:0] text);
    int n;
    int k;
    ascii_word_t w;
    n = 0;
    k = 0;
    if (text == BAD_BASE) begin
      w.glyph = '0;
      w.last  = 1'b1;
      w.error = 1'b1;
      pending_digits.push_back(w);
      return;
    end
    for (int i = 0; i < TEXT_W / 8; i++)
      if (text[i*8 +: 8] != 8'h00) n++;
    for (int i = TEXT_W / 8 - 1; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'h00) begin
        k++;
        w.glyph = text[i*8 +: CHAR_W];
        w.last  = (k == n);
        w.error = 1'b0;
        pending_digits.push_back(w);
      end
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input int base);
    longint unsigned p;
    int b;
    b = ((base >= 2 && base <= 16) || base == 64) ? base : 10;
    p = 1;
    case ($urandom_range(0, 5))
      0, 5: return VALUE_W'($urandom());
      1: return VALUE_W'($urandom_range(0, b * b));
      2: begin
        // powers of the base and one below, where the digit count steps
        repeat ($urandom_range(1, 31))
          if (p * b <= 64'h7FFF_FFFF) p = p * b;
        return ($urandom_range(0, 1) != 0) ? VALUE_W'(p) : VALUE_W'(p - 1);
      end
      3: return ($urandom_range(0, 1) != 0) ? '0 : '1;
      default: return VALUE_W'($urandom() >> $urandom_range(0, 31));
    endcase
  endfunction

  function automatic int pick_base(input bit legal);
    int b;
    if (legal) begin
      b = $urandom_range(2, 17);
      return (b == 17) ? 64 : b;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1);
    b = $urandom_range(17, 127);
    return (b == 64) ? 127 : b;
  endfunction

  task automatic push_value(input logic [VALUE_W-1:0] v, input logic [TEXT_W-1:0] text);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (text == PREDICT) predict_digits(v);
    else expect_text(text);
    values_sent++;
    @(negedge clk);
  endtask

  // block is idle once every word is out and the sequencer has settled
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr[ADDR_W-1:2] == REG_RADIX) radix_reg = data[RADIX_W-1:0];
    radix_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= !idle_now();

  always @(posedge clk) begin : check_words
    ascii_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (pending_digits.size() == 0) begin
        $error("unexpected word: digit_char %0h last %0b error %0b",
               out_digit_char, out_last, out_error);
        fault_count++;
      end else begin
        want = pending_digits.pop_front();
        if (out_digit_char !== want.glyph) begin
          $error("digit_char: expected %0h, got %0h", want.glyph, out_digit_char);
          fault_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fault_count++;
        end
        if (out_error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_error);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run
    int base;
    logic [DATA_W-1:0] data;
    vectors = '{
      '{1'b0, RADIX_ADDR, 32'd0,          31'd0,          "0"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'h7FFF_FFFF,  "2147483647"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd1,          "1"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd10,         "10"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd9,          "9"},
      '{1'b1, RADIX_ADDR, 32'd2,          31'h7FFF_FFFF,  "1111111111111111111111111111111"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd0,          "0"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd5,          "101"},
      '{1'b1, RADIX_ADDR, 32'd16,         31'h7FFF_FFFF,  "7FFFFFFF"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'hAB_CDEF,    "ABCDEF"},
      '{1'b1, RADIX_ADDR, 32'd64,         31'h7FFF_FFFF,  "1/////"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd62,         "+"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd36,         "a"},
      '{1'b0, RADIX_ADDR, 32'd0,          31'd35,         "Z"},
      '{1'b1, RADIX_ADDR, 32'd0,          31'd5,          BAD_BASE},
      '{1'b1, RADIX_ADDR, 32'd1,          31'd7,          BAD_BASE},
      '{1'b1, RADIX_ADDR, 32'd17,         31'd0,          BAD_BASE},
      '{1'b1, RADIX_ADDR, 32'd63,         31'd123,        BAD_BASE},
      '{1'b1, RADIX_ADDR, 32'd65,         31'd1,          BAD_BASE},
      '{1'b1, RADIX_ADDR, 32'd127,        31'h7FFF_FFFF,  BAD_BASE},
      // upper data bits dropped, base comes out as ten
      '{1'b1, RADIX_ADDR, 32'hFFFF_FF8A,  31'd255,        "255"},
      // the spare address holds nothing, base stays ten
      '{1'b1, SPARE_ADDR, 32'd3,          31'd255,        "255"},
      '{1'b1, RADIX_ADDR, 32'd3,          31'h7FFF_FFFF,  PREDICT},
      '{1'b1, RADIX_ADDR, 32'd7,          31'd343,        "1000"},
      '{1'b1, RADIX_ADDR, 32'd8,          31'h7FFF_FFFF,  "17777777777"}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_VECTORS; i++) begin
      if (vectors[i].wr) begin
        settle();
        write_reg(vectors[i].addr, vectors[i].wdata);
      end
      push_value(vectors[i].value, vectors[i].text);
    end

    for (int phase = 0; phase < 12; phase++) begin
      steady = (phase == 6 || phase == 7);
      case (phase)
        0: base = 2;
        1: base = 16;
        2: base = 64;
        3: base = pick_base(1'b0);
        default: base = pick_base($urandom_range(0, 4) != 0);
      endcase
      settle();
      if (phase % 4 == 3) write_reg(SPARE_ADDR, $urandom());
      data = $urandom();
      data[RADIX_W-1:0] = RADIX_W'(base);
      write_reg(RADIX_ADDR, data);
      repeat ($urandom_range(14, 22)) push_value(pick_value(base), PREDICT);
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("converted %0d values into %0d digit words over %0d register writes",
             values_sent, words_seen, radix_writes);
    $display("bases 2..16 and 64, unsupported bases, zero and full-scale values included");
    if (fault_count == 0 && pending_digits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
